FILE: design/ptss_pkg.sv
// Shared types and constants for the preemptive priority task selector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ptss_pkg;

  // Table geometry and stored field widths
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int PRIO_BITS  = 8;
  localparam int TIME_BITS  = 16;
  localparam int ARR_W      = 32;
  localparam int ENTRY_W    = ARR_W + PRIO_BITS;

  // Port field widths
  localparam int IN_SLOT_W  = 4;
  localparam int IN_STATE_W = 2;
  localparam int IN_TIME_W  = 16;
  localparam int IN_PRIO_W  = 8;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  // Input beat kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  // Slot status codes; code three behaves as inactive
  typedef enum logic [1:0] {
    TS_INACTIVE = 2'd0,
    TS_READY    = 2'd1,
    TS_RUNNING  = 2'd2,
    TS_SPARE    = 2'd3
  } task_state_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_RD,
    ST_RUN_CAP,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr;         // load one slot from the input beat
    logic latch_run;  // capture first running slot
    logic rd_run;     // read table at running slot
    logic cap_run;    // capture running priority, clear best
    logic rd_scan;    // read table at scan counter
    logic commit;     // update status, load result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // scan counter at last slot
    logic out_busy;   // result register full and not taken
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: design/ptss_ctrl.sv
// Sequencer for the task selector: accepts beats and steps the datapath
// through the running-slot read, table scan and commit. Uses ptss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptss_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  output logic                    in_ready,
  input  wire ptss_pkg::dp_sts_t  sts,
  output ptss_pkg::ctrl_cmd_t     cmd
);
  import ptss_pkg::*;

  ctrl_state_t state, state_next;
  logic        accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.latch_run = 1'b1;
            state_next    = ST_RUN_RD;
          end
        end
      end
      ST_RUN_RD: begin
        cmd.rd_run = 1'b1;
        state_next = ST_RUN_CAP;
      end
      ST_RUN_CAP: begin
        cmd.cap_run = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last compare lands this cycle
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ptss_dp.sv
// Datapath of the task selector: slot status flops, priority/arrival table,
// scan compare unit and result register. Uses ptss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptss_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ptss_pkg::ctrl_cmd_t               cmd,
  input  wire logic [ptss_pkg::IN_SLOT_W-1:0]    in_slot,
  input  wire logic [ptss_pkg::IN_STATE_W-1:0]   in_state,
  input  wire logic [ptss_pkg::IN_TIME_W-1:0]    in_time,
  input  wire logic [ptss_pkg::IN_PRIO_W-1:0]    in_prio,
  input  wire logic [ptss_pkg::ARR_W-1:0]        in_arr,
  input  wire logic                              out_ready,
  output ptss_pkg::dp_sts_t                      sts,
  output logic                                   out_valid,
  output logic                                   out_found,
  output logic [ptss_pkg::IN_SLOT_W-1:0]         out_chosen,
  output logic                                   out_pre,
  output logic [ptss_pkg::IN_SLOT_W-1:0]         out_pre_slot
);
  import ptss_pkg::*;

  // Slot status and "time left is nonzero" flags, cleared by reset
  logic [1:0]            st [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] nz;
  logic [TASK_SLOTS-1:0] vld;
  logic [TASK_SLOTS-1:0] elig;

  // Priority and arrival table
  logic [ENTRY_W-1:0]    mem [TASK_SLOTS];
  logic [ENTRY_W-1:0]    rd_q;
  logic                  rd_vld_q;
  logic [SLOT_W-1:0]     rd_addr;
  logic [PRIO_BITS-1:0]  rd_prio;
  logic [ARR_W-1:0]      rd_arr;

  logic [SLOT_W-1:0]     wr_idx;
  logic                  wr_ok;

  logic                  run_any;
  logic [SLOT_W-1:0]     run_enc;
  logic                  run_found;
  logic [SLOT_W-1:0]     run_idx;
  logic                  limited;
  logic [PRIO_BITS-1:0]  limit;

  logic [SLOT_W-1:0]     cnt;
  logic                  cmp_vld;
  logic [SLOT_W-1:0]     cmp_idx;
  logic                  take;

  logic                  best_found;
  logic [SLOT_W-1:0]     best_idx;
  logic [PRIO_BITS-1:0]  best_prio;
  logic [ARR_W-1:0]      best_arr;

  logic                  sel_found;
  logic [SLOT_W-1:0]     sel_idx;
  logic                  sel_pre;

  assign wr_idx = SLOT_W'(in_slot);
  assign wr_ok  = (32'(in_slot) < TASK_SLOTS);

  // Ready with time left
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      elig[i] = (st[i] == TS_READY) && nz[i];
    end
  end

  // First running slot in table order
  always_comb begin
    run_any = 1'b0;
    run_enc = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (st[i] == TS_RUNNING) begin
        run_any = 1'b1;
        run_enc = SLOT_W'(i);
      end
    end
  end

  // Final decision from the scan
  always_comb begin
    sel_pre   = limited && best_found;
    sel_found = limited || best_found;
    sel_idx   = (limited && !best_found) ? run_idx : best_idx;
  end

  // Status flops
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        st[i] <= TS_INACTIVE;
      end
      nz  <= '0;
      vld <= '0;
    end else if (cmd.wr && wr_ok) begin
      st[wr_idx]  <= in_state;
      nz[wr_idx]  <= (in_time[TIME_BITS-1:0] != '0);
      vld[wr_idx] <= 1'b1;
    end else if (cmd.commit) begin
      if (sel_pre) begin
        st[run_idx] <= TS_READY;
      end
      if (sel_found) begin
        st[sel_idx] <= TS_RUNNING;
      end
    end
  end

  // Table write and registered read
  assign rd_addr = cmd.rd_scan ? cnt : run_idx;

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem[wr_idx] <= {in_arr, in_prio[PRIO_BITS-1:0]};
    end
    if (cmd.rd_run || cmd.rd_scan) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= vld[rd_addr];
    end
  end

  // Never written entries read as zero
  assign rd_prio = rd_vld_q ? rd_q[PRIO_BITS-1:0] : '0;
  assign rd_arr  = rd_vld_q ? rd_q[ENTRY_W-1:PRIO_BITS] : '0;

  // Candidate compare: priority limit, then priority, then arrival
  assign take = cmp_vld && elig[cmp_idx] && (!limited || (rd_prio < limit)) &&
                (!best_found || (rd_prio < best_prio) ||
                 ((rd_prio == best_prio) && (rd_arr < best_arr)));

  // Scan control and best-so-far registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld    <= 1'b0;
      best_found <= 1'b0;
      limited    <= 1'b0;
      run_found  <= 1'b0;
      cnt        <= '0;
    end else begin
      cmp_vld <= cmd.rd_scan;
      if (cmd.latch_run) begin
        run_found <= run_any;
      end
      if (cmd.cap_run) begin
        limited    <= run_found && nz[run_idx];
        best_found <= 1'b0;
        cnt        <= '0;
      end else if (cmd.rd_scan) begin
        cnt <= cnt + 1'b1;
      end
      if (take) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_run) begin
      run_idx <= run_enc;
    end
    if (cmd.cap_run) begin
      limit <= rd_prio;
    end
    cmp_idx <= cnt;
    if (take) begin
      best_idx  <= cmp_idx;
      best_prio <= rd_prio;
      best_arr  <= rd_arr;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_found    <= sel_found;
      out_chosen   <= sel_found ? IN_SLOT_W'(sel_idx) : '0;
      out_pre      <= sel_pre;
      out_pre_slot <= sel_pre ? IN_SLOT_W'(run_idx) : '0;
    end
  end

  assign sts.scan_last = (32'(cnt) == TASK_SLOTS - 1);
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

`default_nettype wire

FILE: design/preemptive_priority_task_selector_unit.sv
// Preemptive fixed-priority task selector, top level.
// Instantiates ptss_ctrl and ptss_dp; uses ptss_pkg.
//
// Usage:
//   Input stream (s_*): one beat per item. s_tuser is the kind: 0 loads the
//   task slot named in s_tdata, 1 asks for a scheduling decision.
//   Output stream (m_*): one beat per decision, none for a slot load.
// Sequencing:
//   A slot load is written in the cycle it is accepted; s_tready stays high.
//   A decision reads and captures the running slot's priority, then scans one
//   table entry per cycle over all 16 slots through the single read port,
//   passes a drain state and commits; m_tvalid is registered from the commit.
//   s_tready returns once the commit is done, so no new beat is taken while
//   a decision is in work. One item is in work at a time.
// Reset:
//   rst (synchronous, active high) marks all slots inactive with zero time,
//   priority and arrival, and empties the result register.
// Stall:
//   The result register holds a finished decision while m_tready is low;
//   new beats are still accepted, but the next decision waits at commit
//   until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_task_selector_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // slot[3:0], task_state[5:4], time_left[21:6], prio_level[29:22],
  // arrived_at[61:30], zero [63:62]
  input  wire logic [ptss_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind[0]
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // found[0], chosen_slot[4:1], preempted[5], preempted_slot[9:6],
  // zero [15:10]
  output logic [ptss_pkg::OUT_DATA_W-1:0]        m_tdata
);
  import ptss_pkg::*;

  ctrl_cmd_t             cmd;
  dp_sts_t               sts;
  logic                  out_found;
  logic                  out_pre;
  logic [IN_SLOT_W-1:0]  out_chosen;
  logic [IN_SLOT_W-1:0]  out_pre_slot;

  ptss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptss_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_slot      (s_tdata[3:0]),
    .in_state     (s_tdata[5:4]),
    .in_time      (s_tdata[21:6]),
    .in_prio      (s_tdata[29:22]),
    .in_arr       (s_tdata[61:30]),
    .out_ready    (m_tready),
    .sts          (sts),
    .out_valid    (m_tvalid),
    .out_found    (out_found),
    .out_chosen   (out_chosen),
    .out_pre      (out_pre),
    .out_pre_slot (out_pre_slot)
  );

  // Result beat packing
  assign m_tdata = {6'd0, out_pre_slot, out_pre, out_chosen, out_found};

endmodule

`default_nettype wire

FILE: design/ptss_chk.sv
// Port-level checker for the task selector, bound to the top level.
// Uses ptss_pkg for the result beat width.
`timescale 1ns / 1ps
`default_nettype none

module ptss_chk (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [ptss_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ptss_pkg::*;

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // No selection means chosen slot reads zero
  a_chosen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
    else $error("chosen slot nonzero without selection");

  // No preemption means preempted slot reads zero
  a_pre_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[5] |-> m_tdata[9:6] == 4'd0)
    else $error("preempted slot nonzero without preemption");

  // A preemption always hands the processor to a different slot
  a_pre_other: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[0] && (m_tdata[4:1] != m_tdata[9:6]))
    else $error("preemption without a different chosen slot");

endmodule

bind preemptive_priority_task_selector_unit ptss_chk u_ptss_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
